### hdl/bpc_pkg.sv
// ----------------------------------------------------------------------------
// bpc_pkg
// Types and constants shared by the button press and hold classifier.
// ----------------------------------------------------------------------------
package bpc_pkg;

    localparam int unsigned CFG_W  = 16;
    localparam int unsigned CODE_W = 3;
    localparam int unsigned ADDR_W = 4;
    localparam int unsigned APB_W  = 32;

    // Event kinds carried in tuser.
    typedef enum logic [1:0] {
        MODE_TICK = 2'd0,
        MODE_RISE = 2'd1,
        MODE_FALL = 2'd2,
        MODE_READ = 2'd3
    } t_mode;

    // Reported button codes.
    localparam logic [CODE_W-1:0] CODE_IDLE    = 3'd0;
    localparam logic [CODE_W-1:0] CODE_PRESSED = 3'd3;
    localparam logic [CODE_W-1:0] CODE_SHORT   = 3'd4;
    localparam logic [CODE_W-1:0] CODE_MID     = 3'd5;
    localparam logic [CODE_W-1:0] CODE_LONG    = 3'd6;

    // Register indexes (byte address divided by four).
    localparam logic [1:0] REG_PRESS      = 2'd0;
    localparam logic [1:0] REG_HOLD_SHORT = 2'd1;
    localparam logic [1:0] REG_HOLD_MID   = 2'd2;
    localparam logic [1:0] REG_HOLD_LONG  = 2'd3;

    localparam logic [CFG_W-1:0] RST_PRESS      = 16'd5;
    localparam logic [CFG_W-1:0] RST_HOLD_SHORT = 16'd100;
    localparam logic [CFG_W-1:0] RST_HOLD_MID   = 16'd500;
    localparam logic [CFG_W-1:0] RST_HOLD_LONG  = 16'd2000;

    typedef struct packed {
        logic [CFG_W-1:0] press_count;
        logic [CFG_W-1:0] hold_short_count;
        logic [CFG_W-1:0] hold_mid_count;
        logic [CFG_W-1:0] hold_long_count;
    } t_cfg;

    // One event as it enters the classifier stage.
    typedef struct packed {
        logic  fire;
        t_mode mode;
        logic  pin;
    } t_event;

endpackage

### hdl/button_press_hold_classifier_core.sv
// ----------------------------------------------------------------------------
// button_press_hold_classifier_core
// Debounces an active-low button and grades how long it is held.
// ----------------------------------------------------------------------------
//  channel  | direction | payload
//  s_axis   | in        | tdata[0] pin_level, tuser[1:0] mode
//  m_axis   | out       | tdata[2:0] button_code (only for read events)
//  apb      | in/out    | four 16-bit thresholds at byte addresses 0,4,8,12
//
//  One event is taken per cycle into the input register unless stalled;
//  the classifier updates its state as the event leaves it, and a read
//  result is registered for m_axis. A read waits in the input register
//  while the output register is full and not being drained, and the events
//  behind it wait with it; other events never stall. Reset is synchronous and
//  returns all thresholds to their defaults and the classifier to idle.
// ----------------------------------------------------------------------------
module button_press_hold_classifier_core #(
    parameter int unsigned COUNT_WIDTH = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // Input events.
    input  logic                       i_s_axis_tvalid,
    output logic                       o_s_axis_tready,
    input  logic [7:0]                 i_s_axis_tdata,  // [0] pin_level
    input  logic [1:0]                 i_s_axis_tuser,  // [1:0] mode
    // Results.
    output logic                       o_m_axis_tvalid,
    input  logic                       i_m_axis_tready,
    output logic [7:0]                 o_m_axis_tdata,  // [2:0] button_code
    // Configuration.
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [bpc_pkg::ADDR_W-1:0] paddr,
    input  logic [bpc_pkg::APB_W-1:0]  pwdata,
    output logic [bpc_pkg::APB_W-1:0]  prdata,
    output logic                       pready
);
    import bpc_pkg::*;

    t_cfg              w_cfg;
    t_event            w_evt;
    logic [CODE_W-1:0] w_code;

    logic              r_in_valid;
    t_mode             r_in_mode;
    logic              r_in_pin;
    logic              r_out_valid;
    logic [CODE_W-1:0] r_out_code;

    logic              w_out_free;
    logic              w_fire;
    logic              w_is_read;

    bpc_cfg_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    assign w_is_read  = (r_in_mode == MODE_READ);
    assign w_out_free = !r_out_valid || i_m_axis_tready;
    assign w_fire     = r_in_valid && (!w_is_read || w_out_free);
    assign o_s_axis_tready = !r_in_valid || w_fire;

    assign w_evt.fire = w_fire;
    assign w_evt.mode = r_in_mode;
    assign w_evt.pin  = r_in_pin;

    bpc_engine #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_engine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (w_cfg),
        .i_evt   (w_evt),
        .o_code  (w_code)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_s_axis_tready) begin
                r_in_valid <= i_s_axis_tvalid;
            end
            if (w_fire && w_is_read) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_axis_tvalid && o_s_axis_tready) begin
            r_in_mode <= t_mode'(i_s_axis_tuser);
            r_in_pin  <= i_s_axis_tdata[0];
        end
        if (w_fire && w_is_read) begin
            r_out_code <= w_code;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{(8-CODE_W){1'b0}}, r_out_code};

endmodule

### hdl/bpc_cfg_regs.sv
// ----------------------------------------------------------------------------
// bpc_cfg_regs
// APB register file holding the press and hold thresholds.
// ----------------------------------------------------------------------------
module bpc_cfg_regs (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [bpc_pkg::ADDR_W-1:0] paddr,
    input  logic [bpc_pkg::APB_W-1:0]  pwdata,
    output logic [bpc_pkg::APB_W-1:0]  prdata,
    output logic                       pready,
    output bpc_pkg::t_cfg              o_cfg
);
    import bpc_pkg::*;

    t_cfg       r_cfg;
    logic       w_wr;
    logic [1:0] w_idx;
    logic [CFG_W-1:0] w_rd;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    // The two low address bits are not decoded.
    assign w_idx  = paddr[3:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.press_count      <= RST_PRESS;
            r_cfg.hold_short_count <= RST_HOLD_SHORT;
            r_cfg.hold_mid_count   <= RST_HOLD_MID;
            r_cfg.hold_long_count  <= RST_HOLD_LONG;
        end else if (w_wr) begin
            case (w_idx)
                REG_PRESS:      r_cfg.press_count      <= pwdata[CFG_W-1:0];
                REG_HOLD_SHORT: r_cfg.hold_short_count <= pwdata[CFG_W-1:0];
                REG_HOLD_MID:   r_cfg.hold_mid_count   <= pwdata[CFG_W-1:0];
                REG_HOLD_LONG:  r_cfg.hold_long_count  <= pwdata[CFG_W-1:0];
                default:        r_cfg <= r_cfg;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_PRESS:      w_rd = r_cfg.press_count;
            REG_HOLD_SHORT: w_rd = r_cfg.hold_short_count;
            REG_HOLD_MID:   w_rd = r_cfg.hold_mid_count;
            REG_HOLD_LONG:  w_rd = r_cfg.hold_long_count;
            default:        w_rd = '0;
        endcase
    end

    assign prdata = {{(APB_W-CFG_W){1'b0}}, w_rd};
    assign o_cfg  = r_cfg;

endmodule

### hdl/bpc_engine.sv
// ----------------------------------------------------------------------------
// bpc_engine
// Press phase, hold counter and reported code, updated once per event.
// ----------------------------------------------------------------------------
module bpc_engine #(
    parameter int unsigned COUNT_WIDTH = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  bpc_pkg::t_cfg              i_cfg,
    input  bpc_pkg::t_event            i_evt,
    output logic [bpc_pkg::CODE_W-1:0] o_code
);
    import bpc_pkg::*;

    localparam int unsigned CMP_W = (COUNT_WIDTH > CFG_W) ? COUNT_WIDTH : CFG_W;

    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_PENDING = 2'd1,
        PH_HELD    = 2'd2
    } t_phase;

    t_phase                 r_phase,    n_phase;
    logic [CODE_W-1:0]      r_reported, n_reported;
    logic [COUNT_WIDTH-1:0] r_tick,     n_tick;

    logic                   w_moved;
    logic [COUNT_WIDTH-1:0] w_inc;
    logic [CMP_W-1:0]       w_cnt;

    assign w_moved = (r_tick != {COUNT_WIDTH{1'b1}});
    assign w_inc   = w_moved ? (r_tick + COUNT_WIDTH'(1)) : r_tick;
    assign w_cnt   = CMP_W'(w_inc);

    always_comb begin
        n_phase    = r_phase;
        n_reported = r_reported;
        n_tick     = r_tick;
        if (i_evt.fire) begin
            case (i_evt.mode)
                MODE_TICK: begin
                    if (r_phase == PH_PENDING) begin
                        n_tick = w_inc;
                        if (w_moved && w_cnt == CMP_W'(i_cfg.press_count)) begin
                            if (!i_evt.pin) begin
                                n_reported = CODE_PRESSED;
                                n_phase    = PH_HELD;
                            end else begin
                                n_phase    = PH_IDLE;
                                n_reported = CODE_IDLE;
                                n_tick     = '0;
                            end
                        end
                    end else if (r_phase == PH_HELD) begin
                        if (!i_evt.pin) begin
                            n_tick = w_inc;
                            // Short level wins over medium, medium over long.
                            if (w_moved) begin
                                if (w_cnt == CMP_W'(i_cfg.hold_short_count)) begin
                                    n_reported = CODE_SHORT;
                                end else if (w_cnt == CMP_W'(i_cfg.hold_mid_count)) begin
                                    n_reported = CODE_MID;
                                end else if (w_cnt == CMP_W'(i_cfg.hold_long_count)) begin
                                    n_reported = CODE_LONG;
                                end
                            end
                        end else begin
                            n_phase    = PH_IDLE;
                            n_reported = CODE_IDLE;
                            n_tick     = '0;
                        end
                    end
                end
                MODE_RISE: begin
                    if (r_phase != PH_PENDING) begin
                        n_phase    = PH_IDLE;
                        n_reported = CODE_IDLE;
                        n_tick     = '0;
                    end
                end
                MODE_FALL: begin
                    if (r_phase == PH_IDLE) begin
                        n_phase    = PH_PENDING;
                        n_reported = CODE_IDLE;
                        n_tick     = '0;
                    end
                end
                MODE_READ: begin
                    n_reported = CODE_W'(r_phase);
                end
                default: begin
                    n_phase = r_phase;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_IDLE;
            r_reported <= CODE_IDLE;
            r_tick     <= '0;
        end else begin
            r_phase    <= n_phase;
            r_reported <= n_reported;
            r_tick     <= n_tick;
        end
    end

    assign o_code = r_reported;

`ifndef SYNTH
    // The counter only runs while a press is pending or held.
    a_idle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_IDLE |-> r_tick == '0)
        else $error("tick counter nonzero while idle");

    // A read leaves the phase code behind.
    a_read_swap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_evt.fire && i_evt.mode == MODE_READ |=> r_reported == CODE_W'($past(r_phase)))
        else $error("read did not load phase code");

    // While held with the pin low, the counter never goes backward.
    a_hold_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_evt.fire && i_evt.mode == MODE_TICK && r_phase == PH_HELD && !i_evt.pin
        |=> r_tick >= $past(r_tick) && r_phase == PH_HELD)
        else $error("held counter went backward");
`endif

endmodule

### tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the button press and hold classifier core.
// A short table of events checks the idle, pending, confirm and cancel paths.
// Random press sequences then run under several threshold settings, with
// idle bursts on both streams. Every read result is checked against a local
// model of the classifier. One steady hold reaches the default short level,
// and a last setting leaves a press that can never be confirmed.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import bpc_pkg::*;

    localparam int unsigned CNT_W         = 16;
    localparam int unsigned STALL_LIMIT   = 4000;
    localparam int unsigned SETTLE_CYCLES = 8;

    // A read reports the phase code once nothing else has been recorded.
    localparam logic [CODE_W-1:0] CODE_PENDING = 3'd1;
    localparam logic [CODE_W-1:0] CODE_HELD    = 3'd2;

    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_PENDING = 2'd1,
        PH_HELD    = 2'd2
    } t_phase;

    typedef struct packed {
        t_mode             mode;
        logic              pin;
        logic              fixed;
        logic [CODE_W-1:0] code;
    } t_row;

    logic              i_clk;
    logic              i_rst_n  = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [7:0]        s_tdata  = 8'd0;   // [0] pin_level
    logic [1:0]        s_tuser  = 2'd0;   // [1:0] mode
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [7:0]        m_tdata;           // [2:0] button_code
    logic              psel     = 1'b0;
    logic              penable  = 1'b0;
    logic              pwrite   = 1'b0;
    logic [ADDR_W-1:0] paddr    = '0;
    logic [APB_W-1:0]  pwdata   = '0;
    logic [APB_W-1:0]  prdata;
    logic              pready;

    // Local copy of the classifier state and thresholds.
    t_cfg              cfg_q;
    t_phase            ph_q;
    logic [CODE_W-1:0] rep_q;
    logic [CNT_W-1:0]  ticks_q;

    logic [CODE_W-1:0] code_fifo[$];
    logic [CODE_W-1:0] want_code;
    int unsigned       err_count   = 0;
    int unsigned       sent_count  = 0;
    int unsigned       idle_cycles = 0;
    int unsigned       sink_hold   = 0;
    bit                quiet       = 1'b0;

    t_row dir_rows [0:24] = '{
        '{MODE_READ, 1'b0, 1'b1, CODE_IDLE},
        '{MODE_TICK, 1'b0, 1'b0, CODE_IDLE},
        '{MODE_RISE, 1'b1, 1'b0, CODE_IDLE},
        '{MODE_READ, 1'b1, 1'b1, CODE_IDLE},
        '{MODE_FALL, 1'b0, 1'b0, CODE_IDLE},
        '{MODE_FALL, 1'b1, 1'b0, CODE_IDLE},
        '{MODE_RISE, 1'b0, 1'b0, CODE_IDLE},
        '{MODE_READ, 1'b0, 1'b0, CODE_IDLE},
        '{MODE_READ, 1'b1, 1'b0, CODE_IDLE},
        '{MODE_TICK, 1'b0, 1'b0, CODE_IDLE},
        '{MODE_TICK, 1'b0, 1'b0, CODE_IDLE},
        '{MODE_TICK, 1'b0, 1'b0, CODE_IDLE},
        '{MODE_TICK, 1'b0, 1'b0, CODE_IDLE},
        '{MODE_TICK, 1'b0, 1'b0, CODE_IDLE},
        '{MODE_READ, 1'b0, 1'b0, CODE_IDLE},
        '{MODE_READ, 1'b0, 1'b0, CODE_IDLE},
        '{MODE_TICK, 1'b1, 1'b0, CODE_IDLE},
        '{MODE_READ, 1'b1, 1'b0, CODE_IDLE},
        '{MODE_FALL, 1'b1, 1'b0, CODE_IDLE},
        '{MODE_TICK, 1'b0, 1'b0, CODE_IDLE},
        '{MODE_TICK, 1'b0, 1'b0, CODE_IDLE},
        '{MODE_TICK, 1'b0, 1'b0, CODE_IDLE},
        '{MODE_TICK, 1'b0, 1'b0, CODE_IDLE},
        '{MODE_TICK, 1'b1, 1'b0, CODE_IDLE},
        '{MODE_READ, 1'b0, 1'b0, CODE_IDLE}
    };

    button_press_hold_classifier_core #(
        .COUNT_WIDTH(CNT_W)
    ) u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_axis_tvalid(s_tvalid),
        .o_s_axis_tready(s_tready),
        .i_s_axis_tdata (s_tdata),
        .i_s_axis_tuser (s_tuser),
        .o_m_axis_tvalid(m_tvalid),
        .i_m_axis_tready(m_tready),
        .o_m_axis_tdata (m_tdata),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    task automatic report_mismatch(string what, int got, int want);
        err_count++;
        if (err_count <= 100) begin
            $display("mismatch: %s, got %0d, expected %0d, at %0t", what, got, want, $time);
        end
    endtask

    function automatic void clear_state();
        ph_q    = PH_IDLE;
        rep_q   = CODE_IDLE;
        ticks_q = '0;
    endfunction

    // Applies one event to the local state; returns 1 when it yields a result.
    function automatic bit classify_event(input t_mode m, input logic pin,
                                          output logic [CODE_W-1:0] code);
        bit moved;
        bit has = 1'b0;
        code = CODE_IDLE;
        case (m)
            MODE_TICK: begin
                if (ph_q != PH_IDLE) begin
                    // The counter saturates, and a tick that cannot move it
                    // matches no threshold.
                    moved = (ticks_q != '1);
                    if (moved) ticks_q = ticks_q + 1'b1;
                    if (ph_q == PH_PENDING) begin
                        if (moved && ticks_q == cfg_q.press_count) begin
                            if (!pin) begin
                                rep_q = CODE_PRESSED;
                                ph_q  = PH_HELD;
                            end else begin
                                clear_state();
                            end
                        end
                    end else if (pin) begin
                        clear_state();
                    end else if (moved) begin
                        if (ticks_q == cfg_q.hold_short_count) rep_q = CODE_SHORT;
                        else if (ticks_q == cfg_q.hold_mid_count) rep_q = CODE_MID;
                        else if (ticks_q == cfg_q.hold_long_count) rep_q = CODE_LONG;
                    end
                end
            end
            MODE_RISE: begin
                if (ph_q != PH_PENDING) clear_state();
            end
            MODE_FALL: begin
                if (ph_q == PH_IDLE) begin
                    clear_state();
                    ph_q = PH_PENDING;
                end
            end
            default: begin
                code  = rep_q;
                rep_q = {1'b0, ph_q};
                has   = 1'b1;
            end
        endcase
        return has;
    endfunction

    // Sends one event; a fixed code overrides the predicted one for reads.
    task automatic send_event(t_mode m, logic pin, logic fixed = 1'b0,
                              logic [CODE_W-1:0] code = CODE_IDLE);
        logic [CODE_W-1:0] predicted;
        if (!quiet && $urandom_range(0, 9) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, pin};
        s_tuser  <= m;
        do @(posedge i_clk); while (!s_tready);
        if (classify_event(m, pin, predicted)) begin
            code_fifo.push_back(fixed ? code : predicted);
        end
        sent_count++;
    endtask

    task automatic send_noise();
        send_event(t_mode'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
    endtask

    // One press: a falling edge, a run of low ticks, and a release. Wild
    // presses mix in reads, stray events and early releases.
    task automatic gen_press(int lo, int hi, bit wild);
        int n;
        int r;
        n = $urandom_range(hi, lo);
        if (wild && $urandom_range(0, 3) == 0) send_noise();
        send_event(MODE_FALL, 1'($urandom_range(0, 1)));
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 79);
            if (!wild) begin
                if ($urandom_range(0, 1999) == 0) send_event(MODE_READ, 1'b0);
                send_event(MODE_TICK, 1'b0);
            end else if (r < 12) begin
                send_event(MODE_READ, 1'($urandom_range(0, 1)));
            end else if (r < 16) begin
                send_noise();
            end else if (r == 16) begin
                send_event(MODE_TICK, 1'b1);
                break;
            end else begin
                send_event(MODE_TICK, 1'b0);
            end
        end
        if ($urandom_range(0, 1)) send_event(MODE_READ, 1'($urandom_range(0, 1)));
        case ($urandom_range(0, 2))
            0: send_event(MODE_RISE, 1'($urandom_range(0, 1)));
            1: send_event(MODE_TICK, 1'b1);
            default: send_noise();
        endcase
    endtask

    task automatic run_random(int n_items, int hi);
        int unsigned start;
        start = sent_count;
        while (sent_count - start < n_items) gen_press(0, hi, 1'b1);
    endtask

    // Returns the classifier to idle and waits until all results are out.
    task automatic settle_idle();
        while (ph_q == PH_PENDING) send_event(MODE_TICK, 1'b1);
        send_event(MODE_RISE, 1'b0);
        s_tvalid <= 1'b0;
        while (code_fifo.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(logic [1:0] idx, logic [CFG_W-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {{(APB_W-CFG_W){1'b0}}, val};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        // Read the register straight back.
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata[CFG_W-1:0] !== val) begin
            report_mismatch("register readback", int'(prdata[CFG_W-1:0]), int'(val));
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_PRESS:      cfg_q.press_count      = val;
            REG_HOLD_SHORT: cfg_q.hold_short_count = val;
            REG_HOLD_MID:   cfg_q.hold_mid_count   = val;
            default:        cfg_q.hold_long_count  = val;
        endcase
    endtask

    task automatic cfg_all(logic [CFG_W-1:0] press, logic [CFG_W-1:0] short_lvl,
                           logic [CFG_W-1:0] mid_lvl, logic [CFG_W-1:0] long_lvl);
        cfg_write(REG_PRESS, press);
        cfg_write(REG_HOLD_SHORT, short_lvl);
        cfg_write(REG_HOLD_MID, mid_lvl);
        cfg_write(REG_HOLD_LONG, long_lvl);
    endtask

    // Result checker.
    always @(posedge i_clk) begin
        if (i_rst_n && m_tvalid && m_tready) begin
            if (code_fifo.size() == 0) begin
                report_mismatch("result with no read pending", int'(m_tdata[CODE_W-1:0]), 0);
            end else begin
                want_code = code_fifo.pop_front();
                if (m_tdata[CODE_W-1:0] !== want_code) begin
                    report_mismatch("button_code", int'(m_tdata[CODE_W-1:0]), int'(want_code));
                end
            end
        end
    end

    // Result side back-pressure in bursts.
    always @(posedge i_clk) begin
        if (sink_hold > 0) begin
            sink_hold = sink_hold - 1;
            m_tready <= (sink_hold == 0);
        end else if (!quiet && $urandom_range(0, 7) == 0) begin
            sink_hold = $urandom_range(1, 13);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Watchdog on cycles without any transaction.
    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable && pready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles = idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        cfg_q.press_count      = RST_PRESS;
        cfg_q.hold_short_count = RST_HOLD_SHORT;
        cfg_q.hold_mid_count   = RST_HOLD_MID;
        cfg_q.hold_long_count  = RST_HOLD_LONG;
        clear_state();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < 25; i++) begin
            send_event(dir_rows[i].mode, dir_rows[i].pin, dir_rows[i].fixed, dir_rows[i].code);
        end

        // Default thresholds, including one hold that reaches the short level.
        run_random(150, 12);
        gen_press(100, 110, 1'b0);
        run_random(100, 12);
        settle_idle();

        cfg_all(16'd3, 16'd6, 16'd10, 16'd15);
        run_random(300, 20);
        settle_idle();

        // Short level equal to the confirm point, medium level out of reach.
        cfg_all(16'd1, 16'd1, 16'hFFFF, 16'd2);
        run_random(200, 8);
        settle_idle();

        // All hold levels equal: only the short level is ever recorded.
        cfg_all(16'd2, 16'd5, 16'd5, 16'd5);
        run_random(250, 10);
        settle_idle();

        // A zero short level never matches.
        cfg_all(16'd4, 16'd0, 16'd7, 16'd7);
        run_random(250, 12);
        settle_idle();

        quiet = 1'b1;
        // Back-to-back traffic with no idling on either side.
        cfg_all(16'd2, 16'd4, 16'd8, 16'd12);
        run_random(300, 16);
        settle_idle();

        // A zero confirm count leaves the press pending; edges do not clear it.
        cfg_write(REG_PRESS, 16'd0);
        send_event(MODE_FALL, 1'b0);
        repeat (10) send_event(MODE_TICK, 1'b0);
        send_event(MODE_READ, 1'b0);
        send_event(MODE_RISE, 1'b1);
        send_event(MODE_READ, 1'b1);
        send_event(MODE_FALL, 1'b1);
        send_event(MODE_TICK, 1'b1);
        send_event(MODE_READ, 1'b0);

        s_tvalid <= 1'b0;
        while (code_fifo.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (code_fifo.size() != 0) begin
            report_mismatch("results never delivered", code_fifo.size(), 0);
        end
        if (err_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
